// File: rtl/core/ssm_pkg.sv
// Shared types and constants for the sorted stream merge block.
`default_nettype none

package ssm_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CMD_FIFO_DEPTH  = 2;
  localparam int VALUE_W         = 32;

  localparam logic SEQ_FIRST  = 1'b0;
  localparam logic SEQ_SECOND = 1'b1;

  typedef struct packed {
    logic                      command;
    logic                      has_value;
    logic signed [VALUE_W-1:0] value;
    logic                      ends_sequence;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] merged_value;
    logic                      value_valid;
    logic                      last;
    logic                      dropped;
  } out_item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_APPLY,
    B_READ,
    B_DECIDE
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/sorted_stream_merge.sv
// Top level of the two-way merge of ascending sorted streams.
//
//   channel | ports                        | direction | payload
//   --------+------------------------------+-----------+---------------------
//   input   | in_valid, in_stall, in_item  | in        | ssm_pkg::in_item_t
//   result  | out_valid, out_stall, out_item | out     | ssm_pkg::out_item_t
//
// The back sequencer takes and applies each item, then reads and decides once per
// merged value and once more to finish; it stops after the decide that closes the
// merge, and after apply for an item to a closed sequence. The queue RAMs' read is
// registered, hence a read before each decide. A two-entry command queue accepts
// meanwhile and in_stall rises only when it is full. Reset is synchronous, active
// low; queue contents need no clearing. out_stall holds the output and sequencer.
`default_nettype none

module sorted_stream_merge #(
  parameter int QUEUE_DEPTH = ssm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ssm_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ssm_pkg::out_item_t      out_item
);

  logic              cmd_valid;
  logic              cmd_pop;
  ssm_pkg::in_item_t cmd;

  ssm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ssm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: rtl/core/ssm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/ssm_front.sv
// Front part: accepts items, drops empty ones and queues the rest for the back part.
`default_nettype none

module ssm_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ssm_pkg::in_item_t in_item,
  output logic                  cmd_valid,
  output ssm_pkg::in_item_t     cmd,
  input  wire logic             cmd_pop
);

  localparam int DEPTH = ssm_pkg::CMD_FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  ssm_pkg::in_item_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;

  assign in_stall  = (count_r == CW'(DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = slot_r[rd_ptr_r];

  // an item with neither value nor end mark changes nothing: drop it here
  assign push = in_valid && !in_stall && (in_item.has_value || in_item.ends_sequence);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ssm_back.sv
// Back part: per-sequence value queues, merge sequencer and output register.
`default_nettype none

module ssm_back #(
  parameter int QUEUE_DEPTH = ssm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire ssm_pkg::in_item_t cmd,
  output logic                   cmd_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ssm_pkg::out_item_t     out_item
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int VW = ssm_pkg::VALUE_W;

  ssm_pkg::back_state_t state_r, state_nxt;
  ssm_pkg::in_item_t    cur_r, cur_nxt;
  ssm_pkg::out_item_t   out_item_r, emit_item;
  logic                 out_valid_r;
  logic                 emit, out_free;

  logic [AW-1:0] head_r  [2];
  logic [AW-1:0] head_nxt[2];
  logic [AW-1:0] tail_r  [2];
  logic [AW-1:0] tail_nxt[2];
  logic [FW-1:0] fill_r  [2];
  logic [FW-1:0] fill_nxt[2];
  logic [1:0]    ended_r, ended_nxt;
  logic [1:0]    wr_en;
  logic [VW-1:0] rd_data [2];

  logic       s;
  logic [1:0] nonempty, drain;
  logic       first_le, have_src, src, complete, is_last;

  for (genvar i = 0; i < 2; i++) begin : g_queue
    ssm_ram #(
      .WIDTH (VW),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en[i]),
      .wr_addr (tail_r[i]),
      .wr_data (cur_r.value),
      .rd_addr (head_r[i]),
      .rd_data (rd_data[i])
    );
    assign nonempty[i] = (fill_r[i] != '0);
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a queue drains alone once the other has ended and emptied; hold its tail while open
  assign drain[0] = nonempty[0] && !nonempty[1] && ended_r[1] &&
                    (ended_r[0] || fill_r[0] > FW'(1));
  assign drain[1] = nonempty[1] && !nonempty[0] && ended_r[0] &&
                    (ended_r[1] || fill_r[1] > FW'(1));
  assign first_le = ($signed(rd_data[0]) <= $signed(rd_data[1]));
  assign have_src = (nonempty[0] && nonempty[1]) || drain[0] || drain[1];
  assign src      = (nonempty[0] && nonempty[1]) ? !first_le :
                    (drain[0] ? ssm_pkg::SEQ_FIRST : ssm_pkg::SEQ_SECOND);
  assign complete = ended_r[0] && ended_r[1] && !nonempty[0] && !nonempty[1];
  // the pop that empties the last queue after both ends closes the merge
  assign is_last  = ended_r[0] && ended_r[1] && !nonempty[!src] && (fill_r[src] == FW'(1));
  assign s        = cur_r.command;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    ended_nxt = ended_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_nxt  = fill_r;
    wr_en     = '0;
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    emit_item = '0;
    case (state_r)
      ssm_pkg::B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cur_nxt   = cmd;
          state_nxt = ssm_pkg::B_APPLY;
        end
      end
      ssm_pkg::B_APPLY: begin
        if (ended_r[s]) begin
          state_nxt = ssm_pkg::B_IDLE;
        end else if (cur_r.has_value && fill_r[s] == FW'(QUEUE_DEPTH)) begin
          if (out_free) begin
            emit              = 1'b1;
            emit_item.dropped = 1'b1;
            ended_nxt[s]      = ended_r[s] | cur_r.ends_sequence;
            state_nxt         = ssm_pkg::B_READ;
          end
        end else begin
          if (cur_r.has_value) begin
            wr_en[s]    = 1'b1;
            tail_nxt[s] = (tail_r[s] == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r[s] + 1'b1;
            fill_nxt[s] = fill_r[s] + 1'b1;
          end
          ended_nxt[s] = ended_r[s] | cur_r.ends_sequence;
          state_nxt    = ssm_pkg::B_READ;
        end
      end
      ssm_pkg::B_READ: begin
        // head data lands in the RAM output register
        state_nxt = ssm_pkg::B_DECIDE;
      end
      ssm_pkg::B_DECIDE: begin
        if (have_src) begin
          if (out_free) begin
            emit                   = 1'b1;
            emit_item.merged_value = $signed(rd_data[src]);
            emit_item.value_valid  = 1'b1;
            emit_item.last         = is_last;
            if (is_last) begin
              ended_nxt = '0;
              head_nxt  = '{default: '0};
              tail_nxt  = '{default: '0};
              fill_nxt  = '{default: '0};
              state_nxt = ssm_pkg::B_IDLE;
            end else begin
              head_nxt[src] = (head_r[src] == AW'(QUEUE_DEPTH - 1)) ? '0 :
                              head_r[src] + 1'b1;
              fill_nxt[src] = fill_r[src] - 1'b1;
              state_nxt     = ssm_pkg::B_READ;
            end
          end
        end else if (complete) begin
          // both sequences empty: emit a bare last marker
          if (out_free) begin
            emit           = 1'b1;
            emit_item.last = 1'b1;
            ended_nxt      = '0;
            head_nxt       = '{default: '0};
            tail_nxt       = '{default: '0};
            fill_nxt       = '{default: '0};
            state_nxt      = ssm_pkg::B_IDLE;
          end
        end else begin
          state_nxt = ssm_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = ssm_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssm_pkg::B_IDLE;
      ended_r     <= '0;
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      fill_r      <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ended_r <= ended_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_sorted_stream_merge.sv
// Self-checking testbench for sorted_stream_merge: directed edge cases, then random pairs.
`default_nettype none

module tb_sorted_stream_merge;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = ssm_pkg::QUEUE_DEPTH_DEF;
  localparam int MAX_PER_ITEM = 17;
  localparam int ITEM_GOAL    = 330;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 64;

  typedef ssm_pkg::in_item_t item_q_t[$];

  typedef struct packed {
    ssm_pkg::in_item_t  item;
    logic [4:0]         reps;
    logic               typed;
    logic               has_want;
    ssm_pkg::out_item_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  ssm_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  ssm_pkg::out_item_t out_item;

  // merge state mirrored by the predictor
  logic signed [31:0] seq_data [2][DEPTH];
  logic [3:0]         seq_head [2];
  logic [4:0]         seq_fill [2];
  bit                 seq_ended [2];

  ssm_pkg::out_item_t pending_merge[$];
  ssm_pkg::out_item_t step_res[$];
  bit                 step_ignored;
  dir_row_t           plan[$];

  bit calm;
  int squeeze_reqs = 0;
  int idle_cycles  = 0;
  int n_items      = 0;
  int n_results    = 0;
  int n_drops      = 0;
  int n_done       = 0;
  int n_errors     = 0;

  sorted_stream_merge #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic ssm_pkg::in_item_t item_of(logic cmd, logic hv, logic signed [31:0] v,
                                                logic e);
    return '{command: cmd, has_value: hv, value: v, ends_sequence: e};
  endfunction

  function automatic ssm_pkg::out_item_t res_of(logic signed [31:0] v, logic valid,
                                                logic last, logic drop);
    return '{merged_value: v, value_valid: valid, last: last, dropped: drop};
  endfunction

  function automatic void clear_merge_state();
    for (int s = 0; s < 2; s++) begin
      seq_head[s]  = '0;
      seq_fill[s]  = '0;
      seq_ended[s] = 1'b0;
    end
  endfunction

  // a queue may drain alone once the other side has ended empty; keep its tail otherwise
  function automatic bit can_drain(int s);
    return seq_fill[s] != 0 && seq_fill[1-s] == 0 && seq_ended[1-s] &&
           (seq_ended[s] || seq_fill[s] > 1);
  endfunction

  function automatic void predict_merge(ssm_pkg::in_item_t it);
    int                 s;
    int                 src;
    bit                 emitted;
    logic [3:0]         slot;
    ssm_pkg::out_item_t r;
    step_res.delete();
    s = int'(it.command);
    step_ignored = seq_ended[s];
    if (step_ignored) return;
    emitted = 1'b0;
    if (it.has_value) begin
      if (seq_fill[s] == 5'(DEPTH)) begin
        step_res.push_back(res_of(0, 1'b0, 1'b0, 1'b1));
      end else begin
        slot = seq_head[s] + seq_fill[s][3:0];
        seq_data[s][slot] = it.value;
        seq_fill[s]++;
      end
    end
    if (it.ends_sequence) seq_ended[s] = 1'b1;
    while (step_res.size() < MAX_PER_ITEM) begin
      if (seq_fill[0] != 0 && seq_fill[1] != 0)
        src = (seq_data[0][seq_head[0]] <= seq_data[1][seq_head[1]]) ? 0 : 1;
      else if (can_drain(0))
        src = 0;
      else if (can_drain(1))
        src = 1;
      else
        break;
      step_res.push_back(res_of(seq_data[src][seq_head[src]], 1'b1, 1'b0, 1'b0));
      emitted = 1'b1;
      seq_head[src]++;
      seq_fill[src]--;
    end
    if (seq_ended[0] && seq_ended[1] && seq_fill[0] == 0 && seq_fill[1] == 0) begin
      if (emitted) begin
        r = step_res.pop_back();
        r.last = 1'b1;
        step_res.push_back(r);
      end else if (step_res.size() < MAX_PER_ITEM) begin
        step_res.push_back(res_of(0, 1'b0, 1'b1, 1'b0));
      end
      clear_merge_state();
    end
  endfunction

  function automatic void add_row(ssm_pkg::in_item_t it, int reps, bit typed, bit has_want,
                                  ssm_pkg::out_item_t want);
    plan.push_back('{item: it, reps: 5'(reps), typed: typed, has_want: has_want, want: want});
  endfunction

  // offer one item, hold it until taken, then record what it should produce
  task automatic offer(ssm_pkg::in_item_t it, bit typed, bit has_want,
                       ssm_pkg::out_item_t want);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (in_stall);
    predict_merge(it);
    if (!step_ignored) n_items++;
    if (typed) begin
      if (has_want) pending_merge.push_back(want);
    end else begin
      foreach (step_res[i]) pending_merge.push_back(step_res[i]);
    end
    @(negedge clk);
  endtask

  function automatic item_q_t build_seq(logic cmd, int len, bit full_range, bit shuffled);
    int      vals[$];
    item_q_t seq;
    bit      end_on_value;
    for (int i = 0; i < len; i++)
      vals.push_back(full_range ? int'($urandom) : int'($urandom_range(16)) - 8);
    if (!shuffled) vals.sort();
    end_on_value = len > 0 && $urandom_range(1);
    foreach (vals[i])
      seq.push_back(item_of(cmd, 1'b1, vals[i], end_on_value && i == len - 1));
    if (!end_on_value) seq.push_back(item_of(cmd, 1'b0, int'($urandom), 1'b1));
    return seq;
  endfunction

  task automatic run_pair();
    item_q_t           sa;
    item_q_t           sb;
    ssm_pkg::in_item_t it;
    int                la;
    int                lb;
    bit                full_range;
    bit                one_sided;
    bit                a_first;
    bit                from_a;
    la = ($urandom_range(99) < 15) ? $urandom_range(20) : $urandom_range(6);
    lb = ($urandom_range(99) < 15) ? $urandom_range(20) : $urandom_range(6);
    full_range = $urandom_range(1);
    sa = build_seq(ssm_pkg::SEQ_FIRST, la, full_range, $urandom_range(99) < 10);
    sb = build_seq(ssm_pkg::SEQ_SECOND, lb, full_range, $urandom_range(99) < 10);
    one_sided = $urandom_range(99) < 15;
    a_first = $urandom_range(1);
    while (sa.size() + sb.size() > 0) begin
      if (sa.size() == 0)
        from_a = 1'b0;
      else if (sb.size() == 0)
        from_a = 1'b1;
      else if (one_sided)
        from_a = a_first;
      else
        from_a = $urandom_range(1);
      it = from_a ? sa.pop_front() : sb.pop_front();
      offer(it, 1'b0, 1'b0, '0);
      // stray item for a sequence that has just closed while the other is still open
      if (it.ends_sequence && (from_a ? sb.size() : sa.size()) > 0 && $urandom_range(99) < 20)
        offer(item_of(it.command, $urandom_range(1), int'($urandom), $urandom_range(1)),
              1'b0, 1'b0, '0);
    end
  endtask

  task automatic field_check(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name,
               $signed(want_v), $signed(got_v));
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : check_merge
    ssm_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_item.dropped) n_drops++;
      if (out_item.last) n_done++;
      if (pending_merge.size() == 0) begin
        $display("%0t unexpected item: expected none, actual %h", $time, out_item);
        n_errors++;
      end else begin
        want = pending_merge.pop_front();
        field_check("merged_value", want.merged_value, out_item.merged_value);
        field_check("value_valid", 32'(want.value_valid), 32'(out_item.value_valid));
        field_check("last", 32'(want.last), 32'(out_item.last));
        field_check("dropped", 32'(want.dropped), 32'(out_item.dropped));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t watchdog: nothing moved for %0d cycles, %0d items outstanding", $time,
               STALL_LIMIT, pending_merge.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, a quiet stretch, and a long hold-off on each request
  initial begin : receiver
    int hold_left;
    int squeeze_done;
    hold_left = 0;
    squeeze_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (squeeze_done != squeeze_reqs) begin
        squeeze_done++;
        hold_left = HOLD_CYCLES - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = !calm && ($urandom_range(99) < 36);
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    calm        = 1'b0;
    clear_merge_state();

    // both sequences empty
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b0, 0, 1'b1), 1, 1'b1, 1'b0, '0);
    add_row(item_of(ssm_pkg::SEQ_SECOND, 1'b0, 0, 1'b1), 1, 1'b1, 1'b1,
            res_of(0, 1'b0, 1'b1, 1'b0));
    // extremes, ties, and an item for a closed sequence
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b1, 32'sh8000_0000, 1'b0), 1, 1'b1, 1'b0, '0);
    add_row(item_of(ssm_pkg::SEQ_SECOND, 1'b1, 32'sh7fff_ffff, 1'b0), 1, 1'b1, 1'b1,
            res_of(32'sh8000_0000, 1'b1, 1'b0, 1'b0));
    add_row(item_of(ssm_pkg::SEQ_SECOND, 1'b1, 32'sh7fff_ffff, 1'b1), 1, 1'b1, 1'b0, '0);
    add_row(item_of(ssm_pkg::SEQ_SECOND, 1'b1, 5, 1'b1), 1, 1'b1, 1'b0, '0);
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b1, 32'sh7fff_ffff, 1'b1), 1, 1'b0, 1'b0, '0);
    // fill the first queue, overflow it with an end mark, then release all at once
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b1, 0, 1'b0), DEPTH, 1'b1, 1'b0, '0);
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b1, -1, 1'b1), 1, 1'b1, 1'b1,
            res_of(0, 1'b0, 1'b0, 1'b1));
    add_row(item_of(ssm_pkg::SEQ_SECOND, 1'b1, 1, 1'b1), 1, 1'b0, 1'b0, '0);
    // tail held back while the other side is closed and empty
    add_row(item_of(ssm_pkg::SEQ_SECOND, 1'b0, 0, 1'b1), 1, 1'b1, 1'b0, '0);
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b1, 3, 1'b0), 1, 1'b1, 1'b0, '0);
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b1, 7, 1'b0), 1, 1'b1, 1'b1,
            res_of(3, 1'b1, 1'b0, 1'b0));
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b0, 0, 1'b1), 1, 1'b1, 1'b1,
            res_of(7, 1'b1, 1'b1, 1'b0));
    // negative values and a tie on the closing step
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b1, -5, 1'b0), 1, 1'b1, 1'b0, '0);
    add_row(item_of(ssm_pkg::SEQ_SECOND, 1'b1, -6, 1'b0), 1, 1'b1, 1'b1,
            res_of(-6, 1'b1, 1'b0, 1'b0));
    add_row(item_of(ssm_pkg::SEQ_SECOND, 1'b1, 2, 1'b1), 1, 1'b1, 1'b1,
            res_of(-5, 1'b1, 1'b0, 1'b0));
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b1, 2, 1'b1), 1, 1'b0, 1'b0, '0);
    // out-of-order input on one side
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b1, 10, 1'b0), 1, 1'b1, 1'b0, '0);
    add_row(item_of(ssm_pkg::SEQ_FIRST, 1'b1, 4, 1'b1), 1, 1'b1, 1'b0, '0);
    add_row(item_of(ssm_pkg::SEQ_SECOND, 1'b1, 6, 1'b1), 1, 1'b0, 1'b0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i])
      repeat (plan[i].reps) offer(plan[i].item, plan[i].typed, plan[i].has_want, plan[i].want);

    for (int pair = 0; n_items < ITEM_GOAL; pair++) begin
      calm = pair >= 18 && pair < 28;
      if (pair == 8 || pair == 32) squeeze_reqs++;
      run_pair();
    end
    calm = 1'b0;
    in_valid = 1'b0;

    wait (pending_merge.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items, checked %0d results (%0d drop reports, %0d completed merges)",
             n_items, n_results, n_drops, n_done);
    $display("Covered edge values, overflow, held tails, stray items and a long output hold");
    if (n_errors == 0 && pending_merge.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// File: sorted_stream_merge.f
rtl/core/ssm_pkg.sv
rtl/core/ssm_ram.sv
rtl/core/ssm_front.sv
rtl/core/ssm_back.sv
rtl/core/sorted_stream_merge.sv
verif/tb_sorted_stream_merge.sv
